@@ rtl/uect_pkg.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic echo capture tracker package
// Shared types, codes and sensor mapping tables for the tracker unit.
// ----------------------------------------------------------------------------
`default_nettype none

package uect_pkg;

   // Number of sensors tracked, and the code that means no sensor.
   localparam int unsigned NUM_SENSORS = 7;
   localparam logic [2:0] NO_SENSOR = 3'd7;
   localparam logic [15:0] NOT_CAPTURED = 16'hFFFF;
   localparam logic [15:0] SPUR_MAX = 16'hFFFF;

   // Transaction action codes.
   localparam logic [1:0] ACT_TRIGGER = 2'd0;
   localparam logic [1:0] ACT_CAPTURE = 2'd1;
   localparam logic [1:0] ACT_TIMEOUT = 2'd2;

   // Sensor record states.
   localparam logic [2:0] ST_INITIAL      = 3'd0;
   localparam logic [2:0] ST_TRIGGERED    = 3'd1;
   localparam logic [2:0] ST_BEGAN        = 3'd2;
   localparam logic [2:0] ST_ENDED        = 3'd3;
   localparam logic [2:0] ST_OVERCAPTURED = 3'd4;
   localparam logic [2:0] ST_ERROR        = 3'd5;
   localparam logic [2:0] ST_TIMED_OUT    = 3'd6;

   typedef struct packed {
      logic [1:0]  action;
      logic [2:0]  trig_sensor;
      logic        echo_group;
      logic [2:0]  capture_channel;
      logic [15:0] capture_time;
      logic        overcapture;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  affected_sensor;
      logic [2:0]  sensor_state;
      logic [15:0] begin_time;
      logic [15:0] end_time;
      logic [15:0] pulse_width;
      logic        spurious_event;
      logic [15:0] spurious_total;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic execute;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_busy;
   } dp_status_type;

   typedef enum logic [0:0] {
      CTL_IDLE,
      CTL_EXEC
   } ctl_state_type;

   // Capture group that a sensor belongs to.
   function automatic logic group_of(input logic [2:0] idx);
      logic grp;
      case (idx)
         3'd4, 3'd5, 3'd6: grp = 1'b1;
         default:          grp = 1'b0;
      endcase
      return grp;
   endfunction

   // Capture channel that a sensor is wired to.
   function automatic logic [2:0] channel_of(input logic [2:0] idx);
      logic [2:0] chan;
      case (idx)
         3'd0:    chan = 3'd1;
         3'd1:    chan = 3'd2;
         3'd2:    chan = 3'd3;
         3'd3:    chan = 3'd4;
         3'd4:    chan = 3'd1;
         3'd5:    chan = 3'd3;
         3'd6:    chan = 3'd4;
         default: chan = 3'd0;
      endcase
      return chan;
   endfunction

endpackage

`default_nettype wire

@@ rtl/uect_ctrl.sv @@
// ----------------------------------------------------------------------------
// Tracker controller
// Sequences each transaction: capture the item, then apply it to the sensor
// table once the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module uect_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire uect_pkg::dp_status_type dp_status,
   output uect_pkg::ctl_cmd_type        ctl_cmd
);
   import uect_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in          = state_ff;
      req_ready         = 1'b0;
      ctl_cmd.load_item = 1'b0;
      ctl_cmd.execute   = 1'b0;
      case (state_ff)
         CTL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl_cmd.load_item = 1'b1;
               state_in          = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            // Apply the item only when the result register can take the result.
            if (!dp_status.out_busy) begin
               ctl_cmd.execute = 1'b1;
               state_in        = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/uect_datapath.sv @@
// ----------------------------------------------------------------------------
// Tracker datapath
// Holds the sensor records, group owners and spurious counter, applies one
// transaction on command and registers its result.
// ----------------------------------------------------------------------------
`default_nettype none

module uect_datapath (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire uect_pkg::req_payload_type req_payload,
   input  wire uect_pkg::ctl_cmd_type     ctl_cmd,
   output uect_pkg::dp_status_type        dp_status,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output uect_pkg::rsp_payload_type      rsp_payload
);
   import uect_pkg::*;

   req_payload_type item_ff;
   logic [2:0]      status_ff [NUM_SENSORS];
   logic [2:0]      status_in [NUM_SENSORS];
   logic [15:0]     start_ff  [NUM_SENSORS];
   logic [15:0]     start_in  [NUM_SENSORS];
   logic [15:0]     stop_ff   [NUM_SENSORS];
   logic [15:0]     stop_in   [NUM_SENSORS];
   logic [2:0]      owner_ff  [2];
   logic [2:0]      owner_in  [2];
   logic [15:0]     spur_ff;
   logic [15:0]     spur_in;
   rsp_payload_type rsp_ff;
   rsp_payload_type rsp_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;

   logic [2:0]      tgt;
   logic            tgt_ok;
   logic [2:0]      cur_st;
   logic [15:0]     cur_start;
   logic [15:0]     cur_stop;
   logic [2:0]      new_st;
   logic [15:0]     new_start;
   logic [15:0]     new_stop;
   logic            emit_sensor;
   logic            write_rec;
   logic            spur_hit;
   logic            free_grp;
   logic            own_write;
   logic            own_grp;
   logic [15:0]     spur_next;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign dp_status.out_busy = rsp_valid_ff && !rsp_ready;

   // Input item register.
   always_ff @(posedge clock) begin
      if (ctl_cmd.load_item) begin
         item_ff <= req_payload;
      end
   end

   // Target sensor: the triggered one, or the owner of the event's group.
   always_comb begin
      if (item_ff.action == ACT_TRIGGER) begin
         tgt = item_ff.trig_sensor;
      end else begin
         tgt = owner_ff[item_ff.echo_group];
      end
      tgt_ok = (tgt != NO_SENSOR);
      if (tgt_ok) begin
         cur_st    = status_ff[tgt];
         cur_start = start_ff[tgt];
         cur_stop  = stop_ff[tgt];
      end else begin
         cur_st    = ST_INITIAL;
         cur_start = NOT_CAPTURED;
         cur_stop  = NOT_CAPTURED;
      end
   end

   // Record update decision for the transaction.
   always_comb begin
      new_st      = cur_st;
      new_start   = cur_start;
      new_stop    = cur_stop;
      emit_sensor = 1'b0;
      write_rec   = 1'b0;
      spur_hit    = 1'b0;
      free_grp    = 1'b0;
      own_write   = 1'b0;
      own_grp     = item_ff.echo_group;
      case (item_ff.action)
         ACT_TRIGGER: begin
            if (tgt_ok) begin
               new_st      = ST_TRIGGERED;
               new_start   = NOT_CAPTURED;
               new_stop    = NOT_CAPTURED;
               emit_sensor = 1'b1;
               write_rec   = 1'b1;
               own_write   = 1'b1;
               own_grp     = group_of(tgt);
            end
         end
         ACT_CAPTURE: begin
            if (!tgt_ok || channel_of(tgt) != item_ff.capture_channel) begin
               spur_hit = 1'b1;
            end else begin
               emit_sensor = 1'b1;
               write_rec   = 1'b1;
               if (cur_st == ST_TRIGGERED) begin
                  if (item_ff.overcapture) begin
                     new_st   = ST_OVERCAPTURED;
                     free_grp = 1'b1;
                  end else begin
                     new_st    = ST_BEGAN;
                     new_start = item_ff.capture_time;
                  end
               end else if (cur_st == ST_BEGAN) begin
                  free_grp = 1'b1;
                  if (item_ff.overcapture) begin
                     new_st = ST_ERROR;
                  end else begin
                     new_st   = ST_ENDED;
                     new_stop = item_ff.capture_time;
                  end
               end
            end
         end
         ACT_TIMEOUT: begin
            if (!tgt_ok) begin
               spur_hit = 1'b1;
            end else begin
               new_st      = ST_TIMED_OUT;
               emit_sensor = 1'b1;
               write_rec   = 1'b1;
               free_grp    = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Saturating spurious count.
   assign spur_next = (spur_hit && spur_ff != SPUR_MAX) ? spur_ff + 16'd1 : spur_ff;

   // Next values of the table, counter and result register.
   always_comb begin
      status_in    = status_ff;
      start_in     = start_ff;
      stop_in      = stop_ff;
      owner_in     = owner_ff;
      spur_in      = spur_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (ctl_cmd.execute) begin
         spur_in      = spur_next;
         rsp_valid_in = 1'b1;
         if (write_rec) begin
            status_in[tgt] = new_st;
            start_in[tgt]  = new_start;
            stop_in[tgt]   = new_stop;
         end
         if (own_write) begin
            owner_in[own_grp] = tgt;
         end else if (free_grp) begin
            owner_in[own_grp] = NO_SENSOR;
         end
         rsp_in.spurious_event = spur_hit;
         rsp_in.spurious_total = spur_next;
         if (emit_sensor) begin
            rsp_in.affected_sensor = tgt;
            rsp_in.sensor_state    = new_st;
            rsp_in.begin_time      = new_start;
            rsp_in.end_time        = new_stop;
            rsp_in.pulse_width     = (new_st == ST_ENDED) ? new_stop - new_start : 16'd0;
         end else begin
            rsp_in.affected_sensor = NO_SENSOR;
            rsp_in.sensor_state    = ST_INITIAL;
            rsp_in.begin_time      = 16'd0;
            rsp_in.end_time        = 16'd0;
            rsp_in.pulse_width     = 16'd0;
         end
      end
   end

   // Sensor table, owners, counter and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SENSORS; i++) begin
            status_ff[i] <= ST_INITIAL;
            start_ff[i]  <= NOT_CAPTURED;
            stop_ff[i]   <= NOT_CAPTURED;
         end
         owner_ff[0]  <= NO_SENSOR;
         owner_ff[1]  <= NO_SENSOR;
         spur_ff      <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         status_ff    <= status_in;
         start_ff     <= start_in;
         stop_ff      <= stop_in;
         owner_ff     <= owner_in;
         spur_ff      <= spur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

@@ rtl/ultrasonic_echo_capture_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic echo capture tracker unit
// Tracks echo pulse begin and end times for seven sensors on two capture
// groups and counts events that belong to no measurement.
//
//   Channel   Direction  Ports
//   request   in         req_valid, req_ready, req_payload
//   response  out        rsp_valid, rsp_ready, rsp_payload
//
// Each transaction registers the item and then applies it to the sensor
// table; the controller's two states set the pace.
// A new item is taken while the previous result waits in the output register;
// the apply step waits only while that register is full and not being drained.
// Reset clears all sensor records, group owners and the spurious count at once.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_capture_tracker_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire uect_pkg::req_payload_type req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output uect_pkg::rsp_payload_type      rsp_payload
);
   import uect_pkg::*;

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_status;

   // Transaction sequencer.
   uect_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .ctl_cmd   (ctl_cmd)
   );

   // Sensor table and result register.
   uect_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .ctl_cmd     (ctl_cmd),
      .dp_status   (dp_status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
